>>> rtl/sps_pkg.sv
// Package for the stepper phase sequencer: item codes, mode codes, register map,
// step-count constants, coil pattern tables and the result record.
// No dependencies.
package sps_pkg;

  // Steps per quarter rotation of the motor.
  localparam int unsigned SPQ = 512;

  localparam int unsigned STEPS_W   = 26;
  localparam logic [STEPS_W-1:0] STEPS_MAX = {STEPS_W{1'b1}};

  // |amount| needs one more bit than the field, for -32768.
  localparam int unsigned MAG_W  = 17;
  localparam int unsigned SPQ_W  = $clog2(SPQ + 1);
  localparam int unsigned QTR_W  = MAG_W + SPQ_W + 1;

  // Degrees: mag * SPQ * 4 / 360 = mag * SPQ / 90, and mag * SPQ / 45 in half step.
  // mag * SPQ / 45 is taken as (mag * DEG_MULT) >> DEG_SHIFT, exact for mag < 2^17.
  localparam int unsigned DEG_SHIFT  = 24;
  localparam int unsigned DEG_MULT_W = 32;
  localparam logic [DEG_MULT_W-1:0] DEG_MULT =
    DEG_MULT_W'((64'(SPQ) * (64'd1 << DEG_SHIFT) + 64'd44) / 64'd45);
  localparam int unsigned DEG_PW = MAG_W + DEG_MULT_W;
  localparam int unsigned DEG_QW = DEG_PW - DEG_SHIFT;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_STEPS   = 2'd1,
    KIND_QUARTER = 2'd2,
    KIND_DEGREES = 2'd3
  } kind_e;

  localparam logic [1:0] MODE_WAVE = 2'd0;
  localparam logic [1:0] MODE_FULL = 2'd1;
  localparam logic [1:0] MODE_HALF = 2'd2;

  localparam logic REG_MODE     = 1'b0;
  localparam logic REG_DURATION = 1'b1;

  localparam logic [1:0]  MODE_RESET     = MODE_WAVE;
  localparam logic [15:0] DURATION_RESET = 16'd3;

  typedef struct packed {
    logic [3:0] coils;
    logic       busy;
    logic       done;
    logic       rejected;
  } result_t;

  function automatic logic [3:0] pattern_for(input logic [1:0] mode, input logic [2:0] ph);
    logic [3:0] pat;
    pat = 4'h0;
    if (mode == MODE_WAVE) begin
      case (ph[1:0])
        2'd0:    pat = 4'h8;
        2'd1:    pat = 4'h4;
        2'd2:    pat = 4'h2;
        default: pat = 4'h1;
      endcase
    end else if (mode == MODE_FULL) begin
      case (ph[1:0])
        2'd0:    pat = 4'hC;
        2'd1:    pat = 4'h6;
        2'd2:    pat = 4'h3;
        default: pat = 4'h9;
      endcase
    end else begin
      case (ph)
        3'd0:    pat = 4'h8;
        3'd1:    pat = 4'hC;
        3'd2:    pat = 4'h4;
        3'd3:    pat = 4'h6;
        3'd4:    pat = 4'h2;
        3'd5:    pat = 4'h3;
        3'd6:    pat = 4'h1;
        default: pat = 4'h9;
      endcase
    end
    return pat;
  endfunction

endpackage

>>> rtl/stepper_phase_sequencer.sv
// Top level of the stepper phase sequencer: command and tick handling, APB
// register port and a two-entry output buffer. Uses sps_pkg.

// One item (tick or move command) is taken per clock while not stalled and
// gives one result. State update and result are worked out in the transfer
// cycle; the result is then registered in the output register. A second entry
// holds a result when the output stalls, so in_stall_o rises only when both are
// full. Degree moves use one constant multiplier in that same cycle. Registers
// must be written over APB only while no item is in flight (not enforced).
module stepper_phase_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic signed [15:0] amount_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  coils_o,
  output logic        busy_res_o,
  output logic        move_done_o,
  output logic        rejected_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration
  logic [1:0]  mode_q;
  logic [15:0] duration_q;

  // motion state
  logic [2:0]                  phase_q, phase_d;
  logic [sps_pkg::STEPS_W-1:0] remain_q, remain_d;
  logic                        rev_q, rev_d;
  logic [15:0]                 hold_q, hold_d;
  logic [3:0]                  pattern_q, pattern_d;
  logic                        moving_q, moving_d;

  // output buffer
  logic             out_valid_q, skid_valid_q;
  sps_pkg::result_t out_q, skid_q;
  sps_pkg::result_t res;

  logic in_fire, out_fire, cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign in_stall_o = skid_valid_q;
  assign in_fire  = in_valid_i & ~skid_valid_q;
  assign out_fire = out_valid_q & ~out_stall_i;

  always_comb begin
    case (paddr[2])
      sps_pkg::REG_MODE:     prdata = {30'd0, mode_q};
      sps_pkg::REG_DURATION: prdata = {16'd0, duration_q};
      default:               prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= sps_pkg::MODE_RESET;
      duration_q <= sps_pkg::DURATION_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        sps_pkg::REG_MODE:     mode_q     <= pwdata[1:0];
        sps_pkg::REG_DURATION: duration_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // move size conversion
  logic                        neg, half;
  logic [sps_pkg::MAG_W-1:0]   mag;
  logic [sps_pkg::QTR_W-1:0]   qtr_steps;
  logic [sps_pkg::DEG_PW-1:0]  deg_prod;
  logic [sps_pkg::DEG_QW-1:0]  deg_q45, deg_steps;
  logic [sps_pkg::STEPS_W-1:0] steps;

  assign neg  = amount_i[15];
  assign mag  = neg ? (sps_pkg::MAG_W'(0) - sps_pkg::MAG_W'(amount_i))
                    : sps_pkg::MAG_W'(amount_i);
  assign half = mode_q >= sps_pkg::MODE_HALF;

  always_comb begin
    qtr_steps = sps_pkg::QTR_W'(mag) * sps_pkg::QTR_W'(sps_pkg::SPQ);
    if (half) qtr_steps = qtr_steps << 1;
    deg_prod  = sps_pkg::DEG_PW'(mag) * sps_pkg::DEG_PW'(sps_pkg::DEG_MULT);
    deg_q45   = deg_prod[sps_pkg::DEG_PW-1:sps_pkg::DEG_SHIFT];
    deg_steps = half ? deg_q45 : (deg_q45 >> 1);
    case (sps_pkg::kind_e'(kind_i))
      sps_pkg::KIND_QUARTER:
        steps = (qtr_steps > sps_pkg::QTR_W'(sps_pkg::STEPS_MAX)) ? sps_pkg::STEPS_MAX
                : qtr_steps[sps_pkg::STEPS_W-1:0];
      sps_pkg::KIND_DEGREES: steps = sps_pkg::STEPS_W'(deg_steps);
      default:               steps = sps_pkg::STEPS_W'(mag);
    endcase
  end

  // per-item state update and result
  logic [2:0]  phase_step;
  logic        step_start;
  logic [3:0]  shown_pat;
  logic [15:0] hold_load;

  always_comb begin
    phase_d   = phase_q;
    remain_d  = remain_q;
    rev_d     = rev_q;
    hold_d    = hold_q;
    pattern_d = pattern_q;
    moving_d  = moving_q;
    res       = '0;
    res.coils = pattern_q;

    step_start = hold_q == 16'd0;
    phase_step = rev_q ? phase_q + 3'd1 : phase_q - 3'd1;
    shown_pat  = step_start ? sps_pkg::pattern_for(mode_q, phase_step) : pattern_q;
    hold_load  = !step_start ? hold_q :
                 (duration_q == 16'd0) ? 16'd1 : duration_q;

    case (sps_pkg::kind_e'(kind_i))
      sps_pkg::KIND_TICK: begin
        if (moving_q) begin
          if (step_start) phase_d = phase_step;
          pattern_d = shown_pat;
          res.coils = shown_pat;
          hold_d    = hold_load - 16'd1;
          if (hold_d == 16'd0) begin
            remain_d = remain_q - sps_pkg::STEPS_W'(1);
            if (remain_d == '0) begin
              moving_d  = 1'b0;
              pattern_d = 4'h0;
              res.done  = 1'b1;
            end
          end
        end
      end
      default: begin
        if (moving_q) begin
          res.rejected = 1'b1;
        end else if (steps != '0) begin
          remain_d = steps;
          rev_d    = neg;
          hold_d   = 16'd0;
          moving_d = 1'b1;
        end
      end
    endcase
    res.busy = moving_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      remain_q  <= '0;
      rev_q     <= 1'b0;
      hold_q    <= '0;
      pattern_q <= '0;
      moving_q  <= 1'b0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      remain_q  <= remain_d;
      rev_q     <= rev_d;
      hold_q    <= hold_d;
      pattern_q <= pattern_d;
      moving_q  <= moving_d;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) skid_valid_q <= 1'b1;
      else                          out_valid_q  <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) out_q <= skid_q;
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) skid_q <= res;
      else                          out_q  <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign coils_o     = out_q.coils;
  assign busy_res_o  = out_q.busy;
  assign move_done_o = out_q.done;
  assign rejected_o  = out_q.rejected;

endmodule
